[rtl/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character constants and decode helpers for the unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int CHAR_BITS_DEF = 16;
  localparam int OUT_BITS      = 16;
  localparam int MAX_OUTS      = 4;
  localparam int QUEUE_DEPTH   = 2;

  // characters are compared at the widest supported code unit
  localparam logic [31:0] CH_BSLASH = 32'h0000_005C;
  localparam logic [31:0] CH_QUOTE  = 32'h0000_0022;
  localparam logic [31:0] CH_U      = 32'h0000_0075;
  localparam logic [31:0] CH_N      = 32'h0000_006E;
  localparam logic [31:0] CH_R      = 32'h0000_0072;
  localparam logic [31:0] CH_T      = 32'h0000_0074;
  localparam logic [31:0] CH_B      = 32'h0000_0062;
  localparam logic [31:0] CH_F      = 32'h0000_0066;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_HEX    = 2'd2
  } mode_e;

  // one decoded request: up to four characters, last flag on the final one
  typedef struct packed {
    logic [MAX_OUTS-1:0][OUT_BITS-1:0] chars;
    logic [1:0]                        last_idx;
    logic                              last;
  } bundle_t;

  typedef struct packed {
    logic    push;
    bundle_t data;
  } q_wr_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } q_rd_t;

  typedef struct packed {
    logic                hit;
    logic [OUT_BITS-1:0] ch;
  } esc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic esc_t esc_map(input logic [31:0] c);
    esc_t r;
    r.hit = 1'b1;
    r.ch  = '0;
    unique case (c)
      CH_BSLASH: r.ch = 16'h005C;
      CH_QUOTE:  r.ch = 16'h0022;
      CH_N:      r.ch = 16'h000A;
      CH_R:      r.ch = 16'h000D;
      CH_T:      r.ch = 16'h0009;
      CH_B:      r.ch = 16'h0008;
      CH_F:      r.ch = 16'h000C;
      default:   r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic hex_t hex_val(input logic [31:0] c);
    hex_t r;
    logic [31:0] d;
    r = '0;
    d = '0;
    if (c >= 32'h30 && c <= 32'h39) begin
      d = c - 32'h30;
      r.ok = 1'b1;
    end else if (c >= 32'h61 && c <= 32'h66) begin
      d = c - 32'h57;
      r.ok = 1'b1;
    end else if (c >= 32'h41 && c <= 32'h46) begin
      d = c - 32'h37;
      r.ok = 1'b1;
    end
    r.val = d[3:0];
    return r;
  endfunction

  // longest prefix of hex digits among four characters, zero if none
  function automatic logic [OUT_BITS-1:0] hex_prefix(input logic [31:0] a,
                                                     input logic [31:0] b,
                                                     input logic [31:0] c,
                                                     input logic [31:0] d);
    logic [3:0][31:0]    s;
    logic [OUT_BITS-1:0] v;
    logic                stop;
    hex_t                h;
    s    = {d, c, b, a};
    v    = '0;
    stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      h = hex_val(s[i]);
      if (!stop && h.ok) begin
        v = {v[OUT_BITS-5:0], h.val};
      end else begin
        stop = 1'b1;
      end
    end
    return v;
  endfunction

endpackage

[rtl/jsu_stream_if.sv]
// ----------------------------------------------------------------------------
// jsu_stream_if
// Valid/ready channels for escaped input characters and unescaped output.
// ----------------------------------------------------------------------------
interface jsu_in_if #(
  parameter int CHAR_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [CHAR_BITS-1:0] char_in;
  logic                 last_in;

  modport source (output valid, char_in, last_in, input ready);
  modport sink   (input valid, char_in, last_in, output ready);
endinterface

interface jsu_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_out;
  logic        last_out;

  modport source (output valid, char_out, last_out, input ready);
  modport sink   (input valid, char_out, last_out, output ready);
endinterface

[rtl/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front
// Accepts escaped characters, tracks escape state and builds at most one request
// of up to four output characters per input character.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; #(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  jsu_in_if.sink       in_i,
  input  logic         q_ready_i,
  output q_wr_t        q_wr_o
);

  mode_e                mode_q, mode_d;
  logic [1:0]           hex_count_q, hex_count_d;
  logic [CHAR_BITS-1:0] held_q [3];
  logic [2:0]           held_we;
  logic                 accept;
  logic [31:0]          cx;
  logic [OUT_BITS-1:0]  c_out;
  bundle_t              bundle;
  logic [2:0]           n_out;

  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid & q_ready_i;
  assign cx         = 32'(in_i.char_in);
  assign c_out      = OUT_BITS'(in_i.char_in);

  always_comb begin
    logic [3:0][31:0] s;
    logic [1:0]       len;
    logic             skip;
    esc_t             e;
    mode_d      = mode_q;
    hex_count_d = hex_count_q;
    held_we     = '0;
    bundle      = '0;
    n_out       = '0;
    s           = '0;
    len         = '0;
    skip        = 1'b0;
    e           = esc_map(cx);
    unique case (mode_q)
      MODE_ESC: begin
        mode_d = MODE_NORMAL;
        if (e.hit) begin
          bundle.chars[0] = e.ch;
          n_out = 3'd1;
        end else if (cx == CH_U) begin
          if (in_i.last_in) begin
            bundle.chars[0] = OUT_BITS'(CH_U);
            n_out = 3'd1;
          end else begin
            mode_d      = MODE_HEX;
            hex_count_d = '0;
          end
        end else begin
          bundle.chars[0] = OUT_BITS'(CH_BSLASH);
          bundle.chars[1] = c_out;
          n_out = 3'd2;
        end
      end
      MODE_HEX: begin
        if (hex_count_q == 2'd3) begin
          bundle.chars[0] = hex_prefix(32'(held_q[0]), 32'(held_q[1]),
                                       32'(held_q[2]), cx);
          n_out       = 3'd1;
          mode_d      = MODE_NORMAL;
          hex_count_d = '0;
        end else if (in_i.last_in) begin
          // string ends inside \u: emit 'u', then decode held chars again
          bundle.chars[0] = OUT_BITS'(CH_U);
          n_out = 3'd1;
          for (int i = 0; i < 3; i++) begin
            if (i < int'(hex_count_q)) begin
              s[i] = 32'(held_q[i]);
            end else if (i == int'(hex_count_q)) begin
              s[i] = cx;
            end
          end
          len = 2'(hex_count_q + 2'd1);
          for (int i = 0; i < 3; i++) begin
            if (skip) begin
              skip = 1'b0;
            end else if (i < int'(len)) begin
              if (s[i] == CH_BSLASH && (i + 1) < int'(len)) begin
                e = esc_map(s[i+1]);
                if (e.hit) begin
                  bundle.chars[n_out[1:0]] = e.ch;
                  n_out = n_out + 3'd1;
                  skip  = 1'b1;
                end else if (s[i+1] != CH_U) begin
                  bundle.chars[n_out[1:0]] = OUT_BITS'(s[i]);
                  n_out = n_out + 3'd1;
                end
                // backslash before 'u' is dropped
              end else begin
                bundle.chars[n_out[1:0]] = OUT_BITS'(s[i]);
                n_out = n_out + 3'd1;
              end
            end
          end
          mode_d      = MODE_NORMAL;
          hex_count_d = '0;
        end else begin
          for (int j = 0; j < 3; j++) begin
            held_we[j] = (int'(hex_count_q) == j);
          end
          hex_count_d = hex_count_q + 2'd1;
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
        if (cx == CH_BSLASH) begin
          if (in_i.last_in) begin
            bundle.chars[0] = OUT_BITS'(CH_BSLASH);
            n_out = 3'd1;
          end else begin
            mode_d = MODE_ESC;
          end
        end else begin
          bundle.chars[0] = c_out;
          n_out = 3'd1;
        end
      end
    endcase
    bundle.last     = in_i.last_in;
    bundle.last_idx = 2'(n_out - 3'd1);
  end

  assign q_wr_o.push = accept & (n_out != 3'd0);
  assign q_wr_o.data = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NORMAL;
      hex_count_q <= '0;
    end else if (accept) begin
      mode_q      <= mode_d;
      hex_count_q <= hex_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (accept && held_we[j]) begin
        held_q[j] <= in_i.char_in;
      end
    end
  end

endmodule

[rtl/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue
// Two-entry queue of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t q_wr_i,
  output logic  ready_o,
  output q_rd_t q_rd_o,
  input  logic  pop_i
);

  localparam int PtrBits = $clog2(QUEUE_DEPTH);

  bundle_t              mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]     count_q;
  logic                 do_push, do_pop;

  assign ready_o      = (count_q != (PtrBits+1)'(QUEUE_DEPTH));
  assign q_rd_o.valid = (count_q != '0);
  assign q_rd_o.data  = mem_q[rd_ptr_q];
  assign do_push      = q_wr_i.push & ready_o;
  assign do_pop       = pop_i & q_rd_o.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PtrBits'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= PtrBits'(rd_ptr_q + 1'b1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_q <= count_q + (PtrBits+1)'(1);
        2'b01:   count_q <= count_q - (PtrBits+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= q_wr_i.data;
    end
  end

endmodule

[rtl/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back
// Serializes each queued request, one character per cycle unless stalled.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_rd_t    q_rd_i,
  output logic     pop_o,
  jsu_out_if.source out_o
);

  logic [1:0] idx_q;
  logic       at_end;
  logic       fire;

  assign at_end         = (idx_q == q_rd_i.data.last_idx);
  assign fire           = out_o.valid & out_o.ready;
  assign out_o.valid    = q_rd_i.valid;
  assign out_o.char_out = q_rd_i.data.chars[idx_q];
  assign out_o.last_out = at_end & q_rd_i.data.last;
  assign pop_o          = fire & at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

[rtl/json_string_unescape.sv]
// path: a character that yields output is written to the request queue, from which
//   the back serializer shows its results one per cycle while out_o is ready
// throughput: one input character per cycle while each yields at most one output and
//   out_o is ready; a character with more outputs holds out_o until all are sent
// reset: asynchronous active low; clears escape state and the two-entry queue
// ----------------------------------------------------------------------------
// json_string_unescape
// Streaming unescaper for the body of a JSON string, front decode and back
// serializer joined by a short request queue.
// ----------------------------------------------------------------------------
module json_string_unescape import jsu_pkg::*; #(
  parameter int CHAR_BITS = CHAR_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_ready;
  logic  pop;

  jsu_front #(
    .CHAR_BITS(CHAR_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .q_wr_o    (q_wr)
  );

  jsu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_wr_i  (q_wr),
    .ready_o (q_ready),
    .q_rd_o  (q_rd),
    .pop_i   (pop)
  );

  jsu_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_rd_i (q_rd),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
